@@ hw/rtl/cowms_pkg.sv @@
`timescale 1ns / 1ps

package cowms_pkg;

   // Bucket ring size and derived widths
   localparam int NUM_BUCKETS = 8;
   localparam int BIDX_W      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int CNT_W       = $clog2(NUM_BUCKETS + 1);

   // Fixed field widths
   localparam int DATA_W   = 64;
   localparam int DUR_W    = 40;
   localparam int REMOTE_W = 32;
   localparam int LOCAL_W  = 63;
   localparam int UNW_W    = 54;

   localparam logic [DUR_W-1:0] DUR_RESET = 40'd2000000000;

   // Flags from the shared adder
   typedef struct packed {
      logic carry;
      logic slt;
   } cowms_flags_type;

endpackage

@@ hw/rtl/cowms_alu.sv @@
`timescale 1ns / 1ps

module cowms_alu import cowms_pkg::*; (
   input  logic [DATA_W-1:0] alu_a,
   input  logic [DATA_W-1:0] alu_b,
   input  logic              alu_sub,
   output logic [DATA_W-1:0] alu_res,
   output cowms_flags_type   alu_flags
);

   logic [DATA_W-1:0] b_eff;
   logic [DATA_W:0]   sum;
   logic              ovf;

   // Add or subtract with carry out for unsigned compares
   assign b_eff = alu_sub ? ~alu_b : alu_b;
   assign sum   = {1'b0, alu_a} + {1'b0, b_eff} + {{DATA_W{1'b0}}, alu_sub};
   assign alu_res = sum[DATA_W-1:0];

   // Signed less-than from sign and overflow of a - b
   assign ovf = (alu_a[DATA_W-1] != b_eff[DATA_W-1]) ? 1'b0
                : (sum[DATA_W-1] != alu_a[DATA_W-1]);
   assign alu_flags.carry = sum[DATA_W];
   assign alu_flags.slt   = sum[DATA_W-1] ^ ovf;

endmodule

@@ hw/rtl/cowms_bank.sv @@
`timescale 1ns / 1ps

module cowms_bank import cowms_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [BIDX_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [BIDX_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [NUM_BUCKETS];
   logic [DATA_W-1:0] rd_data_ff;

   // Write one bucket minimum
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register read data, hold it between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/clock_offset_windowed_min_sync_top.sv @@
`timescale 1ns / 1ps

// Windowed-minimum clock offset tracker. Each request pairs a remote 32-bit
// microsecond counter with the local nanosecond receive time; the block
// unwraps the remote counter, forms the offset candidate local - 1000*remote,
// keeps per-bucket minimum offsets in a ring of NUM_BUCKETS buckets rotated
// every bucket_duration_ns, and answers with the remote time mapped to local
// nanoseconds using the minimum offset over all buckets. All 64-bit arithmetic
// goes through one shared adder/comparator stepped by a sequencer, so the block
// takes one request at a time: each request steps through the multiply,
// candidate and elapsed-time states, merges into the current bucket or opens
// a new one (the very first request instead fills the whole bucket ring), and
// then scans all buckets for the minimum; a stalled response register adds
// its wait on top. The next request is taken as soon as the result sits in
// the response register. The duration register should be written only while
// the block is idle.

module clock_offset_windowed_min_sync_top import cowms_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [REMOTE_W-1:0]        req_remote_time_us,
   input  logic [LOCAL_W-1:0]         req_local_time_ns,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [DATA_W-1:0]   rsp_synced_time_ns,
   output logic signed [DATA_W-1:0]   rsp_best_offset,
   output logic [UNW_W-1:0]           rsp_unwrapped_remote_us,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [DUR_W-1:0]           csr_bucket_duration_ns
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL1  = 4'd1;
   localparam logic [3:0] ST_MUL2  = 4'd2;
   localparam logic [3:0] ST_CAND  = 4'd3;
   localparam logic [3:0] ST_ELAP  = 4'd4;
   localparam logic [3:0] ST_CMP   = 4'd5;
   localparam logic [3:0] ST_MERGE = 4'd6;
   localparam logic [3:0] ST_FILL  = 4'd7;
   localparam logic [3:0] ST_SCAN  = 4'd8;
   localparam logic [3:0] ST_DONE  = 4'd9;

   // Control state
   logic [3:0]          state_ff, state_in;
   logic                started_ff, started_in;
   logic [REMOTE_W-1:0] prev_ff, prev_in;
   logic [REMOTE_W-1:0] wrap_ff, wrap_in;
   logic [BIDX_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                pend_ff, pend_in;
   logic                first_ff, first_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DUR_W-1:0]    dur_ff, dur_in;

   // Payload registers
   logic [LOCAL_W-1:0]  loc_ff, loc_in;
   logic [DATA_W-1:0]   unw_ff, unw_in;
   logic [DATA_W-1:0]   tmp_ff, tmp_in;
   logic [DATA_W-1:0]   scaled_ff, scaled_in;
   logic [DATA_W-1:0]   cand_ff, cand_in;
   logic [DATA_W-1:0]   start_ff, start_in;
   logic                ge_ff, ge_in;
   logic [DATA_W-1:0]   best_ff, best_in;
   logic [DATA_W-1:0]   out_sync_ff, out_sync_in;
   logic [DATA_W-1:0]   out_off_ff, out_off_in;
   logic [UNW_W-1:0]    out_unw_ff, out_unw_in;

   // Shared unit and bucket memory ports
   logic [DATA_W-1:0]   alu_a, alu_b, alu_res;
   logic                alu_sub;
   cowms_flags_type     alu_flags;
   logic                wr_en, rd_en;
   logic [BIDX_W-1:0]   wr_addr, rd_addr;
   logic [DATA_W-1:0]   rd_data;
   logic [BIDX_W-1:0]   idx_next;
   logic                req_fire, wrap_hit;

   function automatic logic prev_in_diff_msb(input logic [REMOTE_W-1:0] p,
                                             input logic [REMOTE_W-1:0] r);
      logic [REMOTE_W-1:0] d;
      d = p - r;
      return d[REMOTE_W-1];
   endfunction

   cowms_alu u_alu (
      .alu_a     (alu_a),
      .alu_b     (alu_b),
      .alu_sub   (alu_sub),
      .alu_res   (alu_res),
      .alu_flags (alu_flags)
   );

   cowms_bank u_bank (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cand_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign idx_next  = (idx_ff == BIDX_W'(NUM_BUCKETS - 1)) ? '0 : idx_ff + BIDX_W'(1);

   // Count a wrap when the remote counter falls by half its range or more
   assign wrap_hit = started_ff && (req_remote_time_us < prev_ff)
                     && prev_in_diff_msb(prev_ff, req_remote_time_us);

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      started_in   = started_ff;
      prev_in      = prev_ff;
      wrap_in      = wrap_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff;
      dur_in       = dur_ff;
      loc_in       = loc_ff;
      unw_in       = unw_ff;
      tmp_in       = tmp_ff;
      scaled_in    = scaled_ff;
      cand_in      = cand_ff;
      start_in     = start_ff;
      ge_in        = ge_ff;
      best_in      = best_ff;
      out_sync_in  = out_sync_ff;
      out_off_in   = out_off_ff;
      out_unw_in   = out_unw_ff;
      alu_a        = scaled_ff;
      alu_b        = best_ff;
      alu_sub      = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;

      // Drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_valid && csr_ready) begin
         dur_in = csr_bucket_duration_ns;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               wrap_in  = wrap_hit ? wrap_ff + REMOTE_W'(1) : wrap_ff;
               prev_in  = req_remote_time_us;
               unw_in   = {wrap_in, req_remote_time_us};
               loc_in   = req_local_time_ns;
               state_in = ST_MUL1;
            end
         end
         // Multiply by 1000 as (u << 10) - (u << 4) - (u << 3)
         ST_MUL1: begin
            alu_a    = {unw_ff[DATA_W-11:0], 10'b0};
            alu_b    = {unw_ff[DATA_W-5:0], 4'b0};
            alu_sub  = 1'b1;
            tmp_in   = alu_res;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            alu_a     = tmp_ff;
            alu_b     = {unw_ff[DATA_W-4:0], 3'b0};
            alu_sub   = 1'b1;
            scaled_in = alu_res;
            state_in  = ST_CAND;
         end
         // Form the candidate and fetch the current bucket
         ST_CAND: begin
            alu_a    = {1'b0, loc_ff};
            alu_b    = scaled_ff;
            alu_sub  = 1'b1;
            cand_in  = alu_res;
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            state_in = ST_ELAP;
         end
         // Elapsed time since bucket start, flagged when not below zero
         ST_ELAP: begin
            alu_a   = {1'b0, loc_ff};
            alu_b   = start_ff;
            alu_sub = 1'b1;
            tmp_in  = alu_res;
            ge_in   = alu_flags.carry;
            cnt_in  = '0;
            if (started_ff) begin
               state_in = ST_CMP;
            end else begin
               state_in = ST_FILL;
            end
         end
         // Rotate when elapsed exceeds the duration
         ST_CMP: begin
            alu_a   = {{(DATA_W-DUR_W){1'b0}}, dur_ff};
            alu_b   = tmp_ff;
            alu_sub = 1'b1;
            if (ge_ff && !alu_flags.carry) begin
               idx_in   = idx_next;
               start_in = {1'b0, loc_ff};
               wr_en    = 1'b1;
               wr_addr  = idx_next;
               cnt_in   = '0;
               first_in = 1'b1;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_MERGE;
            end
         end
         // Keep the smaller of bucket and candidate
         ST_MERGE: begin
            alu_a    = cand_ff;
            alu_b    = rd_data;
            alu_sub  = 1'b1;
            wr_en    = alu_flags.slt;
            wr_addr  = idx_ff;
            cnt_in   = '0;
            first_in = 1'b1;
            state_in = ST_SCAN;
         end
         // First request: seed every bucket
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[BIDX_W-1:0];
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_BUCKETS - 1)) begin
               start_in   = {1'b0, loc_ff};
               started_in = 1'b1;
               cnt_in     = '0;
               first_in   = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         // Read buckets in turn, fold each into the running minimum
         ST_SCAN: begin
            rd_en   = (cnt_ff != CNT_W'(NUM_BUCKETS));
            rd_addr = cnt_ff[BIDX_W-1:0];
            pend_in = rd_en;
            if (rd_en) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            alu_a   = rd_data;
            alu_b   = best_ff;
            alu_sub = 1'b1;
            if (pend_ff) begin
               if (first_ff || alu_flags.slt) begin
                  best_in = rd_data;
               end
               first_in = 1'b0;
               if (!rd_en) begin
                  state_in = ST_DONE;
               end
            end
         end
         // Map remote time into local time, hold until the slot frees
         ST_DONE: begin
            alu_a   = scaled_ff;
            alu_b   = best_ff;
            alu_sub = 1'b0;
            if (!rsp_valid_ff || rsp_ready) begin
               out_sync_in  = alu_res;
               out_off_in   = best_ff;
               out_unw_in   = unw_ff[UNW_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         prev_ff      <= '0;
         wrap_ff      <= '0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dur_ff       <= DUR_RESET;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         prev_ff      <= prev_in;
         wrap_ff      <= wrap_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
         dur_ff       <= dur_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      loc_ff      <= loc_in;
      unw_ff      <= unw_in;
      tmp_ff      <= tmp_in;
      scaled_ff   <= scaled_in;
      cand_ff     <= cand_in;
      start_ff    <= start_in;
      ge_ff       <= ge_in;
      best_ff     <= best_in;
      out_sync_ff <= out_sync_in;
      out_off_ff  <= out_off_in;
      out_unw_ff  <= out_unw_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_synced_time_ns      = $signed(out_sync_ff);
   assign rsp_best_offset         = $signed(out_off_ff);
   assign rsp_unwrapped_remote_us = out_unw_ff;

endmodule

@@ hw/rtl/cowms_checker.sv @@
`timescale 1ns / 1ps

module cowms_checker import cowms_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [DATA_W-1:0] rsp_synced_time_ns,
   input logic signed [DATA_W-1:0] rsp_best_offset,
   input logic [UNW_W-1:0]         rsp_unwrapped_remote_us
);

   logic [DATA_W-1:0] diff;
   logic [UNW_W-1:0]  scaled_lo;

   // Low bits of synced - offset must equal unwrapped * 1000
   assign diff      = rsp_synced_time_ns - rsp_best_offset;
   assign scaled_lo = rsp_unwrapped_remote_us * UNW_W'(1000);

   // Reset leaves no response pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Block is busy after taking a request
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one still in work");

   // Stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_best_offset)
                                  && $stable(rsp_synced_time_ns))
      else $error("stalled response changed");

   // Synced time is consistent with offset and remote time
   a_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> diff[UNW_W-1:0] == scaled_lo)
      else $error("synced time does not match offset and remote time");

endmodule

bind clock_offset_windowed_min_sync_top cowms_checker u_checker (.*);
